@@ sv/tlvp_pkg.sv @@
`timescale 1ns / 1ps

package tlvp_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int MSG_LEN_W   = 16;
  localparam int HDR_BYTES   = 2;

  localparam logic [1:0] EV_VALUE = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_TRUNC = 2'd2;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    PH_STOP = 2'd0,
    PH_TYPE = 2'd1,
    PH_LEN  = 2'd2,
    PH_VAL  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           data_byte;
    logic [MSG_LEN_W-1:0] message_length;
    logic [7:0]           wanted_type;
  } item_t;

  typedef struct packed {
    phase_t                 phase;
    logic [LENGTH_BITS-1:0] byte_offset;
    logic [LENGTH_BITS-1:0] total_length;
    logic [7:0]             current_type;
    logic [7:0]             current_length;
    logic [7:0]             value_count;
    logic [7:0]             search_type;
    logic                   match_seen;
  } state_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] record_type;
    logic [7:0] record_length;
    logic [7:0] value_index;
    logic [7:0] value_byte;
    logic       last_of_record;
    logic       type_match;
    logic       message_done;
  } result_t;

endpackage

@@ sv/tlvp_step.sv @@
`timescale 1ns / 1ps

module tlvp_step (
  input  tlvp_pkg::item_t  item,
  input  tlvp_pkg::state_t st,
  output tlvp_pkg::state_t st_nxt,
  output tlvp_pkg::result_t res,
  output logic             res_valid
);

  localparam int LB = tlvp_pkg::LENGTH_BITS;

  logic [LB-1:0] off_inc;
  logic [LB:0]   off_ext;
  logic [LB:0]   off_inc_ext;
  logic [LB:0]   total_ext;
  logic          no_room_cur;
  logic          no_room_inc;
  logic          overrun;
  logic          match_now;
  logic [8:0]    idx_inc;
  logic          last_val;

  assign off_inc     = st.byte_offset + LB'(1);
  assign off_ext     = {1'b0, st.byte_offset};
  assign off_inc_ext = {1'b0, off_inc};
  assign total_ext   = {1'b0, st.total_length};
  assign no_room_cur = (off_ext + (LB+1)'(tlvp_pkg::HDR_BYTES)) > total_ext;
  assign no_room_inc = (off_inc_ext + (LB+1)'(tlvp_pkg::HDR_BYTES)) > total_ext;
  assign overrun     = (off_inc_ext + (LB+1)'(item.data_byte)) > total_ext;
  assign match_now   = (st.current_type == st.search_type) && !st.match_seen;
  assign idx_inc     = {1'b0, st.value_count} + 9'd1;
  assign last_val    = idx_inc >= {1'b0, st.current_length};

  always_comb begin
    st_nxt    = st;
    res       = '0;
    res_valid = 1'b0;
    if (item.kind == tlvp_pkg::KIND_RESTART) begin
      st_nxt.total_length = LB'(item.message_length);
      st_nxt.search_type  = item.wanted_type;
      st_nxt.byte_offset  = '0;
      st_nxt.match_seen   = 1'b0;
      st_nxt.value_count  = '0;
      st_nxt.phase        = tlvp_pkg::PH_TYPE;
    end else begin
      unique case (st.phase)
        tlvp_pkg::PH_TYPE: begin
          if (no_room_cur) begin
            st_nxt.phase = tlvp_pkg::PH_STOP;
          end else begin
            st_nxt.current_type = item.data_byte;
            st_nxt.byte_offset  = off_inc;
            st_nxt.phase        = tlvp_pkg::PH_LEN;
          end
        end
        tlvp_pkg::PH_LEN: begin
          st_nxt.current_length = item.data_byte;
          st_nxt.byte_offset    = off_inc;
          if (overrun) begin
            st_nxt.phase       = tlvp_pkg::PH_STOP;
            res_valid          = 1'b1;
            res.event_res      = tlvp_pkg::EV_TRUNC;
            res.message_done   = 1'b1;
          end else if (item.data_byte == 8'd0) begin
            if (match_now) begin
              st_nxt.match_seen = 1'b1;
            end
            st_nxt.phase       = no_room_inc ? tlvp_pkg::PH_STOP : tlvp_pkg::PH_TYPE;
            res_valid          = 1'b1;
            res.event_res      = tlvp_pkg::EV_EMPTY;
            res.last_of_record = 1'b1;
            res.type_match     = match_now;
            res.message_done   = no_room_inc;
          end else begin
            st_nxt.value_count = '0;
            st_nxt.phase       = tlvp_pkg::PH_VAL;
          end
        end
        tlvp_pkg::PH_VAL: begin
          st_nxt.byte_offset = off_inc;
          res_valid          = 1'b1;
          res.event_res      = tlvp_pkg::EV_VALUE;
          res.value_index    = st.value_count;
          res.value_byte     = item.data_byte;
          res.last_of_record = last_val;
          res.type_match     = match_now;
          if (last_val) begin
            if (match_now) begin
              st_nxt.match_seen = 1'b1;
            end
            st_nxt.phase       = no_room_inc ? tlvp_pkg::PH_STOP : tlvp_pkg::PH_TYPE;
            st_nxt.value_count = '0;
            res.message_done   = no_room_inc;
          end else begin
            st_nxt.value_count = idx_inc[7:0];
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
    res.record_type   = st_nxt.current_type;
    res.record_length = st_nxt.current_length;
  end

endmodule

@@ sv/tlv_record_parser.sv @@
`timescale 1ns / 1ps

// Type-length-value record parser, one message byte per input transaction.
// A transaction with in_kind set restarts the parser with a new message length
// and a wanted record type; it produces no result. Message bytes then follow
// as type byte, length byte and value bytes. Each value byte gives one result
// transaction, an empty record gives one, and a record that overruns the
// message gives one truncation error after which the message is ignored.
// Both channels use valid and stall; a transaction moves on an edge where
// valid is high and stall is low.
// An accepted byte is held in an input register; the parse step then runs on
// it and its result is loaded into the output register, which drives out_valid.
// Throughput is one byte per cycle while out_stall is low, set by the single
// parse step between the input and output registers, which updates the parser
// state once per byte.
// While out_stall holds a waiting result, the input register keeps its byte
// and in_stall rises only once that register is also full.
// Synchronous reset stops the parser; bytes before the first restart are
// dropped without a result.

module tlv_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_message_length,
  input  logic [7:0]  in_wanted_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_record_length,
  output logic [7:0]  out_value_index,
  output logic [7:0]  out_value_byte,
  output logic        out_last_of_record,
  output logic        out_type_match,
  output logic        out_message_done
);

  logic              s1_valid_r;
  tlvp_pkg::item_t   s1_item_r;
  tlvp_pkg::state_t  state_r;
  tlvp_pkg::state_t  state_nxt;
  logic              out_valid_r;
  tlvp_pkg::result_t out_res_r;
  tlvp_pkg::result_t res_nxt;
  logic              res_valid_nxt;
  logic              advance;
  logic              s1_fire;
  logic              in_fire;

  assign advance  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  tlvp_step u_step (
    .item      (s1_item_r),
    .st        (state_r),
    .st_nxt    (state_nxt),
    .res       (res_nxt),
    .res_valid (res_valid_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: tlvp_pkg::PH_STOP, default: '0};
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r && res_valid_nxt;
      end
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.kind           <= in_kind;
      s1_item_r.data_byte      <= in_data_byte;
      s1_item_r.message_length <= in_message_length;
      s1_item_r.wanted_type    <= in_wanted_type;
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_res_r.event_res;
  assign out_record_type    = out_res_r.record_type;
  assign out_record_length  = out_res_r.record_length;
  assign out_value_index    = out_res_r.value_index;
  assign out_value_byte     = out_res_r.value_byte;
  assign out_last_of_record = out_res_r.last_of_record;
  assign out_type_match     = out_res_r.type_match;
  assign out_message_done   = out_res_r.message_done;

endmodule
